// ===== sv/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared sizes, codes and control/status bundles for the multi-queue buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int SLOTS      = 64;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    // Slot index, and link width that also holds the null code (SLOTS).
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic issue;    // start the accepted item: memory reads and writes
        logic finish;   // update heads, tails and free list, load the result
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a result this cycle
    } dpath_stat_t;

endpackage

// ===== sv/multi_queue_shared_buffer_top.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_top
// Several FIFO queues sharing one slot store through a linked free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per beat: action
//   0 pushes value onto queue_id, action 1 pops from queue_id. Output channel
//   (out_valid/out_ready) returns exactly one result beat per operation:
//   status (0 ok, 1 overflow, 2 underflow) and data_out (popped value, else 0).
//   The block takes no new operation until the current one has finished: the
//   item reads the link store when it is issued, and the next free-list head
//   or queue head is known only once that registered read returns, in the
//   finish state.
//   At reset all queues are empty and every slot is on the free list in
//   index order; never-written links read through per-slot valid bits, so
//   the block is ready as soon as reset is released, with no clearing pass.
//   When the receiver stalls, the result is held in the output register and
//   one more operation is still accepted; it completes once the waiting
//   result has been taken.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [1:0]         queue_id,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] data_out
);

    mqsb_pkg::ctrl_cmd_t   cmd;
    mqsb_pkg::dpath_stat_t stat;

    mqsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mqsb_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .action    (action),
        .queue_id  (queue_id),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data_out  (data_out)
    );

endmodule

// ===== sv/mqsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mqsb_ctrl
// Two-state sequencer: accept and issue an item, then finish it.
// ----------------------------------------------------------------------------
module mqsb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mqsb_pkg::dpath_stat_t  stat,
    output mqsb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIN  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hold the item until the output register has room.
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    property p_issue_then_finish_state;
        @(posedge clk) disable iff (!rst_n)
        cmd.issue |=> (state_reg == S_FIN);
    endproperty
    a_issue_then_finish_state: assert property (p_issue_then_finish_state)
        else $error("issued item did not move the sequencer to finish");

    property p_no_accept_while_busy;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> !in_ready;
    endproperty
    a_no_accept_while_busy: assert property (p_no_accept_while_busy)
        else $error("input ready while an item is still in progress");

    property p_finish_needs_room;
        @(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free;
    endproperty
    a_finish_needs_room: assert property (p_finish_needs_room)
        else $error("finish issued while output register was blocked");

endmodule

// ===== sv/mqsb_dpath.sv =====
// ----------------------------------------------------------------------------
// mqsb_dpath
// Slot store, link store, queue head/tail and free-list registers, and the
// output register.
// ----------------------------------------------------------------------------
module mqsb_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mqsb_pkg::ctrl_cmd_t    cmd,
    output mqsb_pkg::dpath_stat_t  stat,
    input  logic                   action,
    input  logic [1:0]             queue_id,
    input  logic signed [31:0]     value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic signed [31:0]     data_out
);

    // Memories: no reset on contents.
    logic [mqsb_pkg::DATA_WIDTH-1:0] data_mem [mqsb_pkg::SLOTS];
    logic [mqsb_pkg::LINK_W-1:0]     link_mem [mqsb_pkg::SLOTS];

    // A link entry that was never written reads as its reset value.
    logic [mqsb_pkg::SLOTS-1:0]      link_vld_reg;

    logic [mqsb_pkg::LINK_W-1:0]     head_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::LINK_W-1:0]     tail_reg [mqsb_pkg::QUEUES];
    logic [mqsb_pkg::LINK_W-1:0]     free_head_reg;

    // Item in progress.
    logic                            op_pop_reg;
    logic                            op_fail_reg;
    logic                            op_empty_reg;
    logic                            op_last_reg;
    logic [mqsb_pkg::QIDX_W-1:0]     op_q_reg;
    logic [mqsb_pkg::LINK_W-1:0]     op_slot_reg;
    logic [mqsb_pkg::LINK_W-1:0]     link_rst_reg;
    logic                            link_hit_reg;
    logic [mqsb_pkg::LINK_W-1:0]     link_rd_reg;
    logic [mqsb_pkg::DATA_WIDTH-1:0] data_rd_reg;

    logic                            out_valid_reg;
    mqsb_pkg::status_t               status_reg;
    logic [31:0]                     data_out_reg;

    logic [mqsb_pkg::QIDX_W-1:0]     qidx;
    logic                            q_ok;
    logic [mqsb_pkg::LINK_W-1:0]     cur_head;
    logic [mqsb_pkg::LINK_W-1:0]     cur_tail;
    logic                            head_live;
    logic                            is_pop;
    logic [mqsb_pkg::LINK_W-1:0]     slot;
    logic                            fail;
    logic [mqsb_pkg::SLOT_W-1:0]     rd_addr;
    logic                            link_we;
    logic [mqsb_pkg::SLOT_W-1:0]     link_waddr;
    logic [mqsb_pkg::LINK_W-1:0]     link_wdata;
    logic                            data_we;
    logic [mqsb_pkg::LINK_W-1:0]     next_link;
    logic [mqsb_pkg::LINK_W-1:0]     free_next;

    always_comb
    begin
        qidx      = mqsb_pkg::QIDX_W'(queue_id);
        q_ok      = (int'(queue_id) < mqsb_pkg::QUEUES);
        cur_head  = head_reg[qidx];
        cur_tail  = tail_reg[qidx];
        head_live = (cur_head < mqsb_pkg::NIL);
        is_pop    = (action == mqsb_pkg::ACT_POP);

        if (is_pop)
        begin
            slot = q_ok ? cur_head : mqsb_pkg::NIL;
            fail = !(slot < mqsb_pkg::NIL);
        end
        else
        begin
            slot = free_head_reg;
            fail = !q_ok || !(free_head_reg < mqsb_pkg::NIL);
        end

        rd_addr = slot[mqsb_pkg::SLOT_W-1:0];

        // A pop returns its slot to the free list; a push onto a live queue
        // hangs the new slot after the old tail.
        if (is_pop)
        begin
            link_we    = cmd.issue && !fail;
            link_waddr = slot[mqsb_pkg::SLOT_W-1:0];
            link_wdata = free_head_reg;
        end
        else
        begin
            link_we    = cmd.issue && !fail && head_live;
            link_waddr = cur_tail[mqsb_pkg::SLOT_W-1:0];
            link_wdata = slot;
        end

        data_we = cmd.issue && !is_pop && !fail;
    end

    // Read data is captured only when an item is issued, so it survives a
    // stalled finish while the input ports already show the next beat.
    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[rd_addr] <= mqsb_pkg::DATA_WIDTH'($unsigned(value));
        end
        if (cmd.issue)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (cmd.issue)
        begin
            link_rd_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
        end
        else if (link_we)
        begin
            link_vld_reg[link_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            op_pop_reg   <= is_pop;
            op_fail_reg  <= fail;
            op_empty_reg <= !head_live;
            op_last_reg  <= (cur_tail == slot);
            op_q_reg     <= qidx;
            op_slot_reg  <= slot;
            // Slot i resets to link i+1; the last slot thus links the null code.
            link_rst_reg <= mqsb_pkg::LINK_W'(32'(slot) + 32'd1);
            link_hit_reg <= link_vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        next_link = link_hit_reg ? link_rd_reg : link_rst_reg;
        free_next = (next_link < mqsb_pkg::NIL) ? next_link : mqsb_pkg::NIL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mqsb_pkg::QUEUES; i++)
            begin
                head_reg[i] <= mqsb_pkg::NIL;
                tail_reg[i] <= mqsb_pkg::NIL;
            end
            free_head_reg <= '0;
        end
        else if (cmd.finish && !op_fail_reg)
        begin
            if (op_pop_reg)
            begin
                // The tail slot ends its queue, so its link is never consulted.
                head_reg[op_q_reg] <= op_last_reg ? mqsb_pkg::NIL : free_next;
                free_head_reg      <= op_slot_reg;
            end
            else
            begin
                if (op_empty_reg)
                begin
                    head_reg[op_q_reg] <= op_slot_reg;
                end
                tail_reg[op_q_reg] <= op_slot_reg;
                free_head_reg      <= free_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (op_fail_reg)
            begin
                status_reg   <= op_pop_reg ? mqsb_pkg::ST_UNDER : mqsb_pkg::ST_OVER;
                data_out_reg <= '0;
            end
            else
            begin
                status_reg   <= mqsb_pkg::ST_OK;
                data_out_reg <= op_pop_reg ? 32'(data_rd_reg) : 32'd0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign data_out      = data_out_reg;

    property p_free_head_range;
        @(posedge clk) disable iff (!rst_n)
        free_head_reg <= mqsb_pkg::NIL;
    endproperty
    a_free_head_range: assert property (p_free_head_range)
        else $error("free-list head holds neither a slot nor the null code");

    property p_push_sets_tail;
        @(posedge clk) disable iff (!rst_n)
        (cmd.finish && !op_fail_reg && !op_pop_reg)
            |=> (tail_reg[$past(op_q_reg)] == $past(op_slot_reg));
    endproperty
    a_push_sets_tail: assert property (p_push_sets_tail)
        else $error("successful push did not make its slot the tail");

    property p_pop_frees_slot;
        @(posedge clk) disable iff (!rst_n)
        (cmd.finish && !op_fail_reg && op_pop_reg)
            |=> (free_head_reg == $past(op_slot_reg));
    endproperty
    a_pop_frees_slot: assert property (p_pop_frees_slot)
        else $error("popped slot did not become the free-list head");

    property p_no_overwrite_result;
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(data_out_reg));
    endproperty
    a_no_overwrite_result: assert property (p_no_overwrite_result)
        else $error("waiting result was overwritten or dropped");

endmodule
